// ----- hdl/cbf_pkg.sv -----
package cbf_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W    = 32;
  localparam int OUT_W      = 24;
  localparam int CLIP_W     = 23;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Default curve subdivision and input fraction bits.
  localparam int SEGMENTS_DEF  = 10;
  localparam int FRAC_BITS_DEF = 8;

  // The quotient is resolved DIV_BITS bits per pipeline stage.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = OUT_W / DIV_BITS;

  // Register map (word index) and reset values.
  localparam logic [CFG_ADDR_W-3:0] REG_CLIP_LIMIT = '0;
  localparam logic [CLIP_W-1:0]     CLIP_RESET     = 23'd32767;

  // Output coordinate saturation bounds.
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One input segment.
  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] ctrl1_x;
    logic signed [COORD_W-1:0] ctrl1_y;
    logic signed [COORD_W-1:0] ctrl2_x;
    logic signed [COORD_W-1:0] ctrl2_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } cbf_in_t;

  // One line-to point.
  typedef struct packed {
    logic                    draw_target;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic                    visible;
    logic                    last_point;
  } cbf_out_t;

  // Per-point flags that travel alongside the datapath.
  typedef struct packed {
    logic draw_target;
    logic last_point;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
    logic visible;
  } cbf_side_t;

  // Bernstein weight of control point idx at t = k/n, scaled by n^3.
  // Only evaluated on constants at elaboration.
  function automatic longint cbf_weight(input int n, input int k, input int idx);
    longint a;
    longint kk;
    longint res;
    a  = longint'(n - k);
    kk = longint'(k);
    case (idx)
      0:       res = a * a * a;
      1:       res = 3 * kk * a * a;
      2:       res = 3 * kk * kk * a;
      default: res = kk * kk * kk;
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/cbf_div_stage.sv -----
module cbf_div_stage
  import cbf_pkg::*;
#(
  parameter int N3   = SEGMENTS_DEF * SEGMENTS_DEF * SEGMENTS_DEF,
  parameter int N3_W = $clog2(N3 + 1)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [N3_W-1:0]   rem_i,
  input  logic [OUT_W-1:0]  quo_i,
  output logic [N3_W-1:0]   rem_o,
  output logic [OUT_W-1:0]  quo_o
);

  logic [N3_W-1:0]  rem_nxt;
  logic [OUT_W-1:0] quo_nxt;
  logic [N3_W:0]    trial;
  logic [N3_W-1:0]  rem_r;
  logic [OUT_W-1:0] quo_r;

  // Restoring division, DIV_BITS quotient bits per stage. The quotient word
  // starts as the low dividend bits and the quotient bits shift in at the bottom.
  always_comb begin
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    trial   = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {rem_nxt, quo_nxt[OUT_W-1]};
      if (trial >= (N3_W+1)'(N3)) begin
        rem_nxt = N3_W'(trial - (N3_W+1)'(N3));
        quo_nxt = {quo_nxt[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[N3_W-1:0];
        quo_nxt = {quo_nxt[OUT_W-2:0], 1'b0};
      end
    end
  end

  // Stage register; advances with the rest of the pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// ----- hdl/cubic_bezier_flattener_unit.sv -----
// Cubic Bezier flattener. Each segment transfer (four control points, signed
// fixed point with FRAC_BITS fraction bits) produces SEGMENTS line-to points:
// the curve at t = k/SEGMENTS for k = 1..SEGMENTS-1 from constant Bernstein
// weights, then the exact end point, flagged as last. Coordinates are
// truncated toward zero and saturated to 24 bits; a point is visible when
// both exact coordinates lie within +-clip_limit. A segment occupies the
// point issue counter one point at a time, and the next segment is taken
// as its last point issues, so while the output keeps moving one point
// leaves per cycle. A point passes through the pipeline registers in
// order: weights, multiply, two adder levels, magnitude, divider setup,
// six quotient stages of four bits each, and the output register.
// clip_limit sits at byte address 0 of the register port.
module cubic_bezier_flattener_unit
  import cbf_pkg::*;
#(
  parameter int SEGMENTS  = SEGMENTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cbf_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cbf_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int N3      = SEGMENTS * SEGMENTS * SEGMENTS;
  localparam int N3_W    = $clog2(N3 + 1);
  localparam int K_W     = $clog2(SEGMENTS);
  localparam int PROD_W  = COORD_W + N3_W + 1;
  localparam int MAG_W   = PROD_W - 1;
  localparam int EXT_MIN = FRAC_BITS + OUT_W + N3_W;
  localparam int EXT_W   = (MAG_W > EXT_MIN) ? MAG_W : EXT_MIN;
  localparam int BND_W   = CLIP_W + N3_W;
  localparam int VIS_W   = (MAG_W > BND_W + FRAC_BITS) ? MAG_W : BND_W + FRAC_BITS;
  localparam int ST_MAG  = 5;
  localparam int ST_PREP = 6;
  localparam int NST     = ST_PREP + DIV_STAGES + 1;

  localparam logic [EXT_W-1:0] SAT_LIM = EXT_W'(N3) << (OUT_W - 1);

  function automatic logic signed [OUT_W-1:0] fmt_coord(input logic neg, input logic sat,
                                                       input logic [OUT_W-1:0] q);
    logic signed [OUT_W-1:0] res;
    if (sat) begin
      res = neg ? OUT_MIN : OUT_MAX;
    end else if (neg) begin
      res = -$signed(q);
    end else begin
      res = $signed(q);
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CLIP_W-1:0] clip_r;
  logic [BND_W-1:0]  bound_r;
  logic              cfg_wr;
  logic              reg_sel;

  // Issue stage.
  cbf_in_t        hold_r;
  logic           hold_valid_r;
  logic [K_W-1:0] k_idx_r;
  logic           k_last;
  logic           in_take;
  logic           adv;

  // Pipeline registers.
  logic                     valid_r   [1:NST];
  cbf_side_t                side_r    [1:NST-1];
  cbf_side_t                side_nxt  [1:NST-1];
  logic [N3_W-1:0]          wtab      [SEGMENTS][4];
  logic signed [COORD_W-1:0] crd_x_r  [4];
  logic signed [COORD_W-1:0] crd_y_r  [4];
  logic [N3_W-1:0]          w_r       [4];
  logic signed [PROD_W-1:0] prod_x_r  [4];
  logic signed [PROD_W-1:0] prod_y_r  [4];
  logic signed [PROD_W-1:0] pair_x_r  [2];
  logic signed [PROD_W-1:0] pair_y_r  [2];
  logic signed [PROD_W-1:0] sum_x_r;
  logic signed [PROD_W-1:0] sum_y_r;
  logic [MAG_W-1:0]         mag_x_r;
  logic [MAG_W-1:0]         mag_y_r;
  logic [EXT_W-1:0]         mpr_x;
  logic [EXT_W-1:0]         mpr_y;
  logic [VIS_W-1:0]         vis_bound;
  logic [N3_W-1:0]          rem0_x_r;
  logic [N3_W-1:0]          rem0_y_r;
  logic [OUT_W-1:0]         quo0_x_r;
  logic [OUT_W-1:0]         quo0_y_r;
  logic [N3_W-1:0]          rem_x     [DIV_STAGES+1];
  logic [N3_W-1:0]          rem_y     [DIV_STAGES+1];
  logic [OUT_W-1:0]         quo_x     [DIV_STAGES+1];
  logic [OUT_W-1:0]         quo_y     [DIV_STAGES+1];
  cbf_out_t                 out_r;
  cbf_out_t                 out_nxt;
  logic [OUT_W:0]           abs_x;
  logic [OUT_W:0]           abs_y;

  // Register port: always ready, one writable register.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_CLIP_LIMIT);
  assign prdata  = reg_sel ? CFG_DATA_W'(clip_r) : '0;

  // The visibility bound clip_limit * SEGMENTS^3 is kept precomputed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r  <= CLIP_RESET;
      bound_r <= BND_W'(CLIP_RESET) * BND_W'(N3);
    end else if (cfg_wr && reg_sel) begin
      clip_r  <= pwdata[CLIP_W-1:0];
      bound_r <= BND_W'(pwdata[CLIP_W-1:0]) * BND_W'(N3);
    end
  end

  // Constant weight table, one row per point.
  for (genvar g = 0; g < SEGMENTS; g++) begin : g_wrow
    for (genvar j = 0; j < 4; j++) begin : g_wcol
      assign wtab[g][j] = N3_W'(cbf_weight(SEGMENTS, g + 1, j));
    end
  end

  // The whole pipeline moves unless a finished point is held at the output.
  assign adv      = !(valid_r[NST] && out_stall);
  assign k_last   = (k_idx_r == K_W'(SEGMENTS - 1));
  assign in_stall = hold_valid_r && !(adv && k_last);
  assign in_take  = in_valid && !in_stall;

  // Segment hold register and point counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      k_idx_r      <= '0;
    end else if (in_take) begin
      hold_valid_r <= 1'b1;
      k_idx_r      <= '0;
    end else if (hold_valid_r && adv) begin
      if (k_last) begin
        hold_valid_r <= 1'b0;
      end else begin
        k_idx_r <= k_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        valid_r[s] <= 1'b0;
      end
    end else if (adv) begin
      valid_r[1] <= hold_valid_r;
      for (int s = 2; s <= NST; s++) begin
        valid_r[s] <= valid_r[s-1];
      end
    end
  end

  // Flags: filled in at the stage where each becomes known.
  always_comb begin
    side_nxt[1]             = '0;
    side_nxt[1].draw_target = hold_r.mode;
    side_nxt[1].last_point  = k_last;
    for (int s = 2; s < NST; s++) begin
      side_nxt[s] = side_r[s-1];
    end
    side_nxt[ST_MAG].neg_x    = sum_x_r[PROD_W-1];
    side_nxt[ST_MAG].neg_y    = sum_y_r[PROD_W-1];
    side_nxt[ST_PREP].sat_x   = (mpr_x >= SAT_LIM);
    side_nxt[ST_PREP].sat_y   = (mpr_y >= SAT_LIM);
    side_nxt[ST_PREP].visible = (VIS_W'(mag_x_r) <= vis_bound) &&
                                (VIS_W'(mag_y_r) <= vis_bound);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s < NST; s++) begin
        side_r[s] <= side_nxt[s];
      end
    end
  end

  // Divider setup: drop the fraction bits, split remainder and quotient word.
  assign mpr_x     = EXT_W'(mag_x_r) >> FRAC_BITS;
  assign mpr_y     = EXT_W'(mag_y_r) >> FRAC_BITS;
  assign vis_bound = VIS_W'(bound_r) << FRAC_BITS;

  // Arithmetic stages: weights, products, adder tree, magnitude, setup.
  always_ff @(posedge clk) begin
    if (adv) begin
      crd_x_r[0] <= hold_r.start_x;
      crd_x_r[1] <= hold_r.ctrl1_x;
      crd_x_r[2] <= hold_r.ctrl2_x;
      crd_x_r[3] <= hold_r.end_x;
      crd_y_r[0] <= hold_r.start_y;
      crd_y_r[1] <= hold_r.ctrl1_y;
      crd_y_r[2] <= hold_r.ctrl2_y;
      crd_y_r[3] <= hold_r.end_y;
      for (int i = 0; i < 4; i++) begin
        w_r[i]      <= wtab[k_idx_r][i];
        prod_x_r[i] <= crd_x_r[i] * $signed({1'b0, w_r[i]});
        prod_y_r[i] <= crd_y_r[i] * $signed({1'b0, w_r[i]});
      end
      pair_x_r[0] <= prod_x_r[0] + prod_x_r[1];
      pair_x_r[1] <= prod_x_r[2] + prod_x_r[3];
      pair_y_r[0] <= prod_y_r[0] + prod_y_r[1];
      pair_y_r[1] <= prod_y_r[2] + prod_y_r[3];
      sum_x_r     <= pair_x_r[0] + pair_x_r[1];
      sum_y_r     <= pair_y_r[0] + pair_y_r[1];
      mag_x_r     <= MAG_W'(sum_x_r[PROD_W-1] ? -sum_x_r : sum_x_r);
      mag_y_r     <= MAG_W'(sum_y_r[PROD_W-1] ? -sum_y_r : sum_y_r);
      rem0_x_r    <= mpr_x[OUT_W +: N3_W];
      rem0_y_r    <= mpr_y[OUT_W +: N3_W];
      quo0_x_r    <= mpr_x[OUT_W-1:0];
      quo0_y_r    <= mpr_y[OUT_W-1:0];
    end
  end

  // Quotient stages for both coordinates.
  assign rem_x[0] = rem0_x_r;
  assign rem_y[0] = rem0_y_r;
  assign quo_x[0] = quo0_x_r;
  assign quo_y[0] = quo0_y_r;

  for (genvar d = 1; d <= DIV_STAGES; d++) begin : g_div
    cbf_div_stage #(
      .N3   (N3),
      .N3_W (N3_W)
    ) u_div_x (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_x[d-1]),
      .quo_i (quo_x[d-1]),
      .rem_o (rem_x[d]),
      .quo_o (quo_x[d])
    );

    cbf_div_stage #(
      .N3   (N3),
      .N3_W (N3_W)
    ) u_div_y (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_y[d-1]),
      .quo_i (quo_y[d-1]),
      .rem_o (rem_y[d]),
      .quo_o (quo_y[d])
    );
  end

  // Output register: restore the sign and saturate.
  always_comb begin
    out_nxt.draw_target = side_r[NST-1].draw_target;
    out_nxt.point_x     = fmt_coord(side_r[NST-1].neg_x, side_r[NST-1].sat_x,
                                    quo_x[DIV_STAGES]);
    out_nxt.point_y     = fmt_coord(side_r[NST-1].neg_y, side_r[NST-1].sat_y,
                                    quo_y[DIV_STAGES]);
    out_nxt.visible     = side_r[NST-1].visible;
    out_nxt.last_point  = side_r[NST-1].last_point;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r[NST];
  assign out_data  = out_r;

  // Magnitudes of the delivered point, for checking against the clip limit.
  assign abs_x = out_r.point_x[OUT_W-1] ? (~{1'b1, out_r.point_x} + 1'b1)
                                        : {1'b0, out_r.point_x};
  assign abs_y = out_r.point_y[OUT_W-1] ? (~{1'b1, out_r.point_y} + 1'b1)
                                        : {1'b0, out_r.point_y};

  // A taken segment restarts the point counter with the hold register full.
  a_take_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (hold_valid_r && (k_idx_r == '0)))
    else $error("segment transfer did not restart the point counter");

  // Without saturation the x quotient must fit the signed output range.
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[NST-1] && !side_r[NST-1].sat_x) |-> !quo_x[DIV_STAGES][OUT_W-1])
    else $error("x quotient out of range without saturation");

  // A visible point never lies beyond the clip limit after truncation.
  a_visible_in_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.visible) |->
      ((abs_x <= (OUT_W+1)'(clip_r)) && (abs_y <= (OUT_W+1)'(clip_r))))
    else $error("visible point outside clip limit");

endmodule
